// ===== src/rcs_pkg.sv =====
// ----------------------------------------------------------------------------
// rcs_pkg
// shared constants, register codes and control/status bundles of the ring
// cosine similarity unit
// ----------------------------------------------------------------------------
`default_nettype none

package rcs_pkg;

    localparam int DEF_MAX_DOCS   = 16;
    localparam int DEF_MAX_TERMS  = 64;
    localparam int DEF_COUNT_BITS = 16;

    localparam int DOC_COUNT_W = 5;
    localparam int TERMS_W     = 7;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DOC_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TERMS     = 1'b1;

    localparam int IN_DATA_W  = 16;
    localparam int DOC_ID_W   = 4;
    localparam int SIM_W      = 16;
    localparam int OUT_DATA_W = 24;
    localparam int OUT_USER_W = 1;

    // quotient 2^30*dot^2/(na*nb) never exceeds 2^30
    localparam int QUOT_W = 31;
    localparam int ROOT_W = 16;
    localparam int Q_ONE  = 32768;

    typedef struct packed {
        logic load_wr;
        logic run_start;
        logic rd_issue;
        logic mul_start;
        logic mul_step;
        logic div_start;
        logic div_step;
        logic sqrt_start;
        logic sqrt_step;
        logic out_load;
        logic next_row;
    } t_cmd;

    typedef struct packed {
        logic run_done;
        logic last_term;
        logic pipe_empty;
        logic zero_norm;
        logic step_last;
        logic out_free;
        logic last_row;
    } t_sts;

endpackage

`default_nettype wire

// ===== src/rcs_ram.sv =====
// ----------------------------------------------------------------------------
// rcs_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module rcs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [ADDR_W-1:0]        i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [ADDR_W-1:0]        i_raddr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic [ADDR_W-1:0]        i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

`default_nettype wire

// ===== src/rcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// rcs_ctrl
// sequencer: load, per-row accumulate, multiply, divide, root, emit
// ----------------------------------------------------------------------------
`default_nettype none

module rcs_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    output rcs_pkg::t_cmd     o_cmd,
    input  wire rcs_pkg::t_sts i_sts
);
    typedef enum logic [3:0] {
        ST_LOAD, ST_ACC, ST_DRAIN, ST_MUL, ST_DIV0, ST_DIV, ST_SQ0, ST_SQRT, ST_EMIT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load_wr = 1'b1;
                    if (i_sts.run_done) begin
                        o_cmd.run_start = 1'b1;
                        n_state = ST_ACC;
                    end
                end
            end
            ST_ACC: begin
                o_cmd.rd_issue = 1'b1;
                if (i_sts.last_term) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (i_sts.pipe_empty) begin
                    if (i_sts.zero_norm) begin
                        n_state = ST_EMIT;
                    end else begin
                        o_cmd.mul_start = 1'b1;
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (i_sts.step_last) n_state = ST_DIV0;
            end
            ST_DIV0: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.step_last) n_state = ST_SQ0;
            end
            ST_SQ0: begin
                o_cmd.sqrt_start = 1'b1;
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (i_sts.step_last) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.last_row) begin
                        n_state = ST_LOAD;
                    end else begin
                        o_cmd.next_row = 1'b1;
                        n_state = ST_ACC;
                    end
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    assign o_in_ready = (r_state == ST_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== src/rcs_dpath.sv =====
// ----------------------------------------------------------------------------
// rcs_dpath
// config registers, count store, accumulators, shift-add multiplier,
// restoring divider, bitwise square root and output register
// ----------------------------------------------------------------------------
`default_nettype none

module rcs_dpath #(
    parameter int MAX_DOCS   = rcs_pkg::DEF_MAX_DOCS,
    parameter int MAX_TERMS  = rcs_pkg::DEF_MAX_TERMS,
    parameter int COUNT_BITS = rcs_pkg::DEF_COUNT_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [rcs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [rcs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic [rcs_pkg::IN_DATA_W-1:0]    i_count,
    input  wire rcs_pkg::t_cmd                    i_cmd,
    output rcs_pkg::t_sts                         o_sts,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [rcs_pkg::DOC_ID_W-1:0]          o_first_doc,
    output logic [rcs_pkg::DOC_ID_W-1:0]          o_second_doc,
    output logic [rcs_pkg::SIM_W-1:0]             o_similarity,
    output logic                                  o_zero_norm,
    output logic                                  o_last
);
    localparam int STORE_SIZE = MAX_DOCS * MAX_TERMS;
    localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int POS_W      = $clog2(STORE_SIZE + 1);
    localparam int ROW_W      = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;
    localparam int DOCS_W     = $clog2(MAX_DOCS + 1);
    localparam int TRM_W      = $clog2(MAX_TERMS + 1);
    localparam int TIDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int ACC_W      = 2 * COUNT_BITS + TRM_W;
    localparam int PROD_W     = 2 * ACC_W;
    localparam int REM_W      = PROD_W + 1;
    localparam int QW         = rcs_pkg::QUOT_W;
    localparam int RW         = rcs_pkg::ROOT_W;
    localparam int MAX_STEP   = (ACC_W > QW) ? ACC_W : QW;
    localparam int CNT_W      = $clog2(MAX_STEP + 1);

    // configuration
    logic [rcs_pkg::DOC_COUNT_W-1:0] r_doc_count;
    logic [rcs_pkg::TERMS_W-1:0]     r_terms;
    logic [DOCS_W-1:0]               docs;
    logic [TRM_W-1:0]                terms;
    logic [POS_W-1:0]                total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_doc_count <= rcs_pkg::DOC_COUNT_W'(1);
            r_terms     <= rcs_pkg::TERMS_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_index == rcs_pkg::CFG_IDX_DOC_COUNT) begin
                r_doc_count <= i_cfg_data[rcs_pkg::DOC_COUNT_W-1:0];
            end
            if (i_cfg_index == rcs_pkg::CFG_IDX_TERMS) begin
                r_terms <= i_cfg_data[rcs_pkg::TERMS_W-1:0];
            end
        end
    end

    // zero reads as one, too large saturates
    always_comb begin
        if (r_doc_count == '0) begin
            docs = DOCS_W'(1);
        end else if (32'(r_doc_count) > MAX_DOCS) begin
            docs = DOCS_W'(MAX_DOCS);
        end else begin
            docs = DOCS_W'(r_doc_count);
        end
        if (r_terms == '0) begin
            terms = TRM_W'(1);
        end else if (32'(r_terms) > MAX_TERMS) begin
            terms = TRM_W'(MAX_TERMS);
        end else begin
            terms = TRM_W'(r_terms);
        end
        total = POS_W'(int'(docs) * int'(terms));
    end

    // load position
    logic [POS_W-1:0] r_pos;
    logic             run_done;
    logic             ram_we;

    assign run_done = (32'(r_pos) + 32'd1 >= 32'(total));
    assign ram_we   = i_cmd.load_wr && (32'(r_pos) < STORE_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (i_cmd.load_wr) begin
            r_pos <= run_done ? '0 : r_pos + 1'b1;
        end
    end

    // row walk
    logic [ROW_W-1:0]  r_f;
    logic [ADDR_W-1:0] r_base;
    logic [TIDX_W-1:0] r_i;
    logic              last_row;
    logic [ADDR_W-1:0] b_base;
    logic [ADDR_W-1:0] raddr_a, raddr_b;
    logic [COUNT_BITS-1:0] rdata_a, rdata_b;

    assign last_row = (32'(r_f) + 32'd1 == 32'(docs));
    assign b_base   = last_row ? '0 : r_base + ADDR_W'(terms);
    assign raddr_a  = r_base + ADDR_W'(r_i);
    assign raddr_b  = b_base + ADDR_W'(r_i);

    always_ff @(posedge i_clk) begin
        if (i_cmd.run_start) begin
            r_f    <= '0;
            r_base <= '0;
            r_i    <= '0;
        end else if (i_cmd.next_row) begin
            r_f    <= r_f + 1'b1;
            r_base <= r_base + ADDR_W'(terms);
            r_i    <= '0;
        end else if (i_cmd.rd_issue) begin
            r_i    <= r_i + 1'b1;
        end
    end

    rcs_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (STORE_SIZE)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (r_pos[ADDR_W-1:0]),
        .i_wdata   (i_count[COUNT_BITS-1:0]),
        .i_raddr_a (raddr_a),
        .o_rdata_a (rdata_a),
        .i_raddr_b (raddr_b),
        .o_rdata_b (rdata_b)
    );

    // read -> products -> accumulate
    logic r_v1, r_v2;
    logic [2*COUNT_BITS-1:0] r_paa, r_pbb, r_pab;
    logic [ACC_W-1:0]        r_dot, r_na, r_nb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_issue;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_paa <= rdata_a * rdata_a;
        r_pbb <= rdata_b * rdata_b;
        r_pab <= rdata_a * rdata_b;
        if (i_cmd.run_start || i_cmd.next_row) begin
            r_dot <= '0;
            r_na  <= '0;
            r_nb  <= '0;
        end else if (r_v2) begin
            r_dot <= r_dot + ACC_W'(r_pab);
            r_na  <= r_na + ACC_W'(r_paa);
            r_nb  <= r_nb + ACC_W'(r_pbb);
        end
    end

    // shift-add multiply: dot*dot and na*nb, one bit per cycle
    logic [PROD_W-1:0] r_md_d, r_md_n, r_pd, r_pn;
    logic [ACC_W-1:0]  r_mq_d, r_mq_n;
    logic [CNT_W-1:0]  r_cnt;
    // restoring divide and bitwise root
    logic [REM_W-1:0]  r_rem;
    logic [QW-1:0]     r_q;
    logic [RW-1:0]     r_s, r_bit;
    logic              div_ge;
    logic [REM_W-1:0]  div_diff;
    logic [RW-1:0]     trial;
    logic [2*RW-1:0]   trial_sq;

    assign div_ge   = (r_rem >= {1'b0, r_pn});
    assign div_diff = div_ge ? r_rem - {1'b0, r_pn} : r_rem;
    assign trial    = r_s | r_bit;
    assign trial_sq = trial * trial;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_md_d <= PROD_W'(r_dot);
            r_mq_d <= r_dot;
            r_md_n <= PROD_W'(r_na);
            r_mq_n <= r_nb;
            r_pd   <= '0;
            r_pn   <= '0;
            r_cnt  <= CNT_W'(ACC_W);
        end else if (i_cmd.mul_step) begin
            if (r_mq_d[0]) r_pd <= r_pd + r_md_d;
            if (r_mq_n[0]) r_pn <= r_pn + r_md_n;
            r_md_d <= r_md_d << 1;
            r_md_n <= r_md_n << 1;
            r_mq_d <= r_mq_d >> 1;
            r_mq_n <= r_mq_n >> 1;
            r_cnt  <= r_cnt - 1'b1;
        end else if (i_cmd.div_start) begin
            r_rem <= {1'b0, r_pd};
            r_q   <= '0;
            r_cnt <= CNT_W'(QW);
        end else if (i_cmd.div_step) begin
            r_rem <= {div_diff[REM_W-2:0], 1'b0};
            r_q   <= {r_q[QW-2:0], div_ge};
            r_cnt <= r_cnt - 1'b1;
        end else if (i_cmd.sqrt_start) begin
            r_s   <= '0;
            r_bit <= {1'b1, {(RW-1){1'b0}}};
            r_cnt <= CNT_W'(RW);
        end else if (i_cmd.sqrt_step) begin
            if (trial_sq <= {1'b0, r_q}) r_s <= trial;
            r_bit <= r_bit >> 1;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // output register
    logic zero_now;
    assign zero_now = (r_na == '0) || (r_nb == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_first_doc  <= rcs_pkg::DOC_ID_W'(32'(r_f));
            o_second_doc <= last_row ? '0 : rcs_pkg::DOC_ID_W'(32'(r_f) + 32'd1);
            o_similarity <= zero_now ? '0 : rcs_pkg::SIM_W'(r_s);
            o_zero_norm  <= zero_now;
            o_last       <= last_row;
        end
    end

    always_comb begin
        o_sts.run_done   = run_done;
        o_sts.last_term  = (32'(r_i) + 32'd1 == 32'(terms));
        o_sts.pipe_empty = !r_v1 && !r_v2;
        o_sts.zero_norm  = zero_now;
        o_sts.step_last  = (r_cnt == CNT_W'(1));
        o_sts.out_free   = !o_out_valid || i_out_ready;
        o_sts.last_row   = last_row;
    end

endmodule

`default_nettype wire

// ===== src/ring_cosine_similarity_unit.sv =====
// ----------------------------------------------------------------------------
// ring_cosine_similarity_unit
// loads a document-term count matrix and emits the cosine similarity of
// each row with the next row, wrapping around, in unsigned q1.15
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake              payload
//  s (in)    in   i_s_tvalid/o_s_tready  tdata: count_value[15:0]
//  m (out)   out  o_m_tvalid/i_m_tready  tdata: first_doc, second_doc,
//                                        similarity; tuser: zero_norm;
//                                        tlast: last
//  cfg       in   i_cfg_valid/o_cfg_ready index 0 doc_count, 1 terms_per_doc
//
//  counts load one per cycle into the store; the final count of the matrix
//  starts the run, and no count is taken until the last result is loaded
//  into the output register.
//  per row: accumulate (dual-port store read, product stage, accumulate),
//  shift-add multiply, restoring divide, bitwise root, then emit; a row
//  with a zero norm skips the arithmetic.
//  synchronous active-low reset clears control state and sets both
//  registers to 1; the store has no reset and needs no clearing pass.
//  a stalled output holds the sequencer in its emit step.
// ----------------------------------------------------------------------------
`default_nettype none

module ring_cosine_similarity_unit #(
    parameter int MAX_DOCS   = rcs_pkg::DEF_MAX_DOCS,
    parameter int MAX_TERMS  = rcs_pkg::DEF_MAX_TERMS,
    parameter int COUNT_BITS = rcs_pkg::DEF_COUNT_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input stream
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [rcs_pkg::IN_DATA_W-1:0]     i_s_tdata,   // [15:0] count_value
    // result stream
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [rcs_pkg::OUT_DATA_W-1:0]         o_m_tdata,   // [3:0] first_doc,
                                                                // [7:4] second_doc,
                                                                // [23:8] similarity
    output logic [rcs_pkg::OUT_USER_W-1:0]         o_m_tuser,   // [0] zero_norm
    output logic                                   o_m_tlast,
    // configuration writes
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [rcs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [rcs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    rcs_pkg::t_cmd cmd;
    rcs_pkg::t_sts sts;

    logic [rcs_pkg::DOC_ID_W-1:0] first_doc, second_doc;
    logic [rcs_pkg::SIM_W-1:0]    similarity;
    logic                         zero_norm;

    // registers are always writable; the user must make writes only while idle, the block itself leaves this unenforced
    assign o_cfg_ready = 1'b1;

    rcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    rcs_dpath #(
        .MAX_DOCS   (MAX_DOCS),
        .MAX_TERMS  (MAX_TERMS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_count      (i_s_tdata),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_valid  (o_m_tvalid),
        .i_out_ready  (i_m_tready),
        .o_first_doc  (first_doc),
        .o_second_doc (second_doc),
        .o_similarity (similarity),
        .o_zero_norm  (zero_norm),
        .o_last       (o_m_tlast)
    );

    assign o_m_tdata = {similarity, second_doc, first_doc};
    assign o_m_tuser = zero_norm;

    // similarity never passes 1.0
    a_sim_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ({16'b0, o_m_tdata[23:8]} <= rcs_pkg::Q_ONE))
        else $error("similarity above one");

    // a zero-norm pair reports zero similarity
    a_zero_sim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata[23:8] == '0))
        else $error("zero norm with nonzero similarity");

    // the final result of a run wraps back to row zero
    a_last_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tlast) |-> (o_m_tdata[7:4] == '0))
        else $error("last result does not wrap");

endmodule

`default_nettype wire

// ===== bench/tb_ring_cosine_similarity_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ring_cosine_similarity_unit
// self-checking bench: loads count matrices under many row/term settings,
// predicts every ring similarity with exact integer math and compares each
// result transaction field by field, with random stalls on both streams
// ----------------------------------------------------------------------------
`default_nettype none

module tb_ring_cosine_similarity_unit;

    localparam int CLK_PERIOD  = 12;
    localparam int STORE_DEPTH = rcs_pkg::DEF_MAX_DOCS * rcs_pkg::DEF_MAX_TERMS;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_WAIT   = 300;   // > one full row of compute
    localparam int HOLD_CYCLES = 400;   // long output stall to back up the input

    typedef struct {
        logic [rcs_pkg::DOC_ID_W-1:0] first;
        logic [rcs_pkg::DOC_ID_W-1:0] second;
        logic [rcs_pkg::SIM_W-1:0]    sim;
        logic                         zero;
        logic                         last;
    } t_sim_result;

    // one line of the directed plan: a register write or a run of equal counts
    typedef struct {
        bit                             is_cfg;
        logic [rcs_pkg::CFG_IDX_W-1:0]  idx;
        logic [rcs_pkg::CFG_DATA_W-1:0] data;
        logic [rcs_pkg::IN_DATA_W-1:0]  value;
        int                             rep;
        bit                             chk;     // typed similarity for a one-result run
        logic [rcs_pkg::SIM_W-1:0]      sim;
        bit                             zero;
    } t_plan_row;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_s_tvalid;
    logic                             o_s_tready;
    logic [rcs_pkg::IN_DATA_W-1:0]    i_s_tdata;
    logic                             o_m_tvalid;
    logic                             i_m_tready;
    logic [rcs_pkg::OUT_DATA_W-1:0]   o_m_tdata;
    logic [rcs_pkg::OUT_USER_W-1:0]   o_m_tuser;
    logic                             o_m_tlast;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [rcs_pkg::CFG_IDX_W-1:0]    i_cfg_index;
    logic [rcs_pkg::CFG_DATA_W-1:0]   i_cfg_data;

    // predictor state
    logic [15:0]                      count_mem [STORE_DEPTH];
    int unsigned                      fill_pos;
    logic [rcs_pkg::DOC_COUNT_W-1:0]  docs_reg;
    logic [rcs_pkg::TERMS_W-1:0]      terms_reg;
    t_sim_result                      pending_q [$];

    int  error_count;
    int  results_seen;
    int  cycle_count;
    bit  quiet;          // no idling in the closing stretch

    ring_cosine_similarity_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // out-of-range register values: zero acts as one, too large saturates
    function automatic int unsigned clip_reg(int unsigned v, int unsigned maxv);
        if (v == 0) return 1;
        return (v > maxv) ? maxv : v;
    endfunction

    // largest s in 0..32768 with s*s*na*nb <= 2^30*dot*dot
    function automatic logic [rcs_pkg::SIM_W-1:0] q15_cosine(longint unsigned dot,
                                                             longint unsigned na,
                                                             longint unsigned nb);
        logic [127:0] norm_prod;
        logic [127:0] dot_side;
        logic [127:0] mid_sq;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        norm_prod = {64'd0, na} * {64'd0, nb};
        dot_side  = ({64'd0, dot} * {64'd0, dot}) << 30;
        lo = 0;
        hi = rcs_pkg::Q_ONE;
        while (lo < hi) begin
            mid    = lo + (hi - lo + 1) / 2;
            mid_sq = 128'(mid) * 128'(mid);
            if (norm_prod * mid_sq <= dot_side) lo = mid;
            else hi = mid - 1;
        end
        return lo[rcs_pkg::SIM_W-1:0];
    endfunction

    // store one accepted count; a completed matrix queues its ring results
    task automatic predict_count(input logic [rcs_pkg::IN_DATA_W-1:0] value);
        int unsigned     docs;
        int unsigned     terms;
        int unsigned     g;
        longint unsigned a;
        longint unsigned b;
        longint unsigned dot;
        longint unsigned na;
        longint unsigned nb;
        t_sim_result     res;
        docs  = clip_reg(docs_reg, rcs_pkg::DEF_MAX_DOCS);
        terms = clip_reg(terms_reg, rcs_pkg::DEF_MAX_TERMS);
        if (fill_pos < STORE_DEPTH) count_mem[fill_pos] = value;
        fill_pos++;
        if (fill_pos < docs * terms) return;
        fill_pos = 0;
        for (int unsigned f = 0; f < docs; f++) begin
            g   = (f + 1) % docs;
            dot = 0;
            na  = 0;
            nb  = 0;
            for (int unsigned i = 0; i < terms; i++) begin
                a   = count_mem[f * terms + i];
                b   = count_mem[g * terms + i];
                dot += a * b;
                na  += a * a;
                nb  += b * b;
            end
            res.first  = f[rcs_pkg::DOC_ID_W-1:0];
            res.second = g[rcs_pkg::DOC_ID_W-1:0];
            res.zero   = (na == 0 || nb == 0);
            res.sim    = res.zero ? '0 : q15_cosine(dot, na, nb);
            res.last   = (f + 1 == docs);
            pending_q.push_back(res);
        end
    endtask

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // offer one count, with an occasional gap first; valid stays up afterwards
    task automatic send_count(input logic [rcs_pkg::IN_DATA_W-1:0] value);
        if (!quiet && $urandom_range(3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        do @(posedge i_clk); while (!o_s_tready);
        predict_count(value);
    endtask

    // register write while the block is idle: all results in and compute drained
    task automatic write_reg(input logic [rcs_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rcs_pkg::CFG_DATA_W-1:0] data);
        i_s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == rcs_pkg::CFG_IDX_DOC_COUNT) docs_reg = data[rcs_pkg::DOC_COUNT_W-1:0];
        else terms_reg = data[rcs_pkg::TERMS_W-1:0];
    endtask

    // result side ready: random stall bursts plus one long hold-off
    int  stall_left;
    int  hold_left;
    bit  hold_done;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (!hold_done && results_seen >= 40) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(7) == 0) begin
                stall_left = $urandom_range(1, 15) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_sim_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (pending_q.size() == 0) begin
                $error("unexpected result transaction, tdata %h", o_m_tdata);
                error_count++;
            end else begin
                want = pending_q.pop_front();
                if (o_m_tdata[3:0] !== want.first) begin
                    $error("first_doc: expected %0d, actual %0d", want.first, o_m_tdata[3:0]);
                    error_count++;
                end
                if (o_m_tdata[7:4] !== want.second) begin
                    $error("second_doc: expected %0d, actual %0d", want.second,
                           o_m_tdata[7:4]);
                    error_count++;
                end
                if (o_m_tdata[23:8] !== want.sim) begin
                    $error("similarity: expected %0d, actual %0d", want.sim, o_m_tdata[23:8]);
                    error_count++;
                end
                if (o_m_tuser[0] !== want.zero) begin
                    $error("zero_norm: expected %0b, actual %0b", want.zero, o_m_tuser[0]);
                    error_count++;
                end
                if (o_m_tlast !== want.last) begin
                    $error("last: expected %0b, actual %0b", want.last, o_m_tlast);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // directed plan
    // ------------------------------------------------------------------------
    t_plan_row plan [24] = '{
        // single 1x1 document: self compare, extremes and the empty row
        '{0, rcs_pkg::CFG_IDX_DOC_COUNT, 7'd0, 16'hFFFF, 1, 1, 16'd32768, 0},
        '{0, rcs_pkg::CFG_IDX_DOC_COUNT, 7'd0, 16'h0000, 1, 1, 16'd0,     1},
        '{0, rcs_pkg::CFG_IDX_DOC_COUNT, 7'd0, 16'h0001, 1, 1, 16'd32768, 0},
        // zero register values act as one
        '{1, rcs_pkg::CFG_IDX_DOC_COUNT, 7'd0, 16'h0000, 0, 0, 16'd0, 0},
        '{1, rcs_pkg::CFG_IDX_TERMS,     7'd0, 16'h0000, 0, 0, 16'd0, 0},
        '{0, rcs_pkg::CFG_IDX_DOC_COUNT, 7'd0, 16'd12345, 1, 1, 16'd32768, 0},
        // 2x2: orthogonal rows, then both rows against an empty row
        '{1, rcs_pkg::CFG_IDX_DOC_COUNT, 7'd2, 16'h0000, 0, 0, 16'd0, 0},
        '{1, rcs_pkg::CFG_IDX_TERMS,     7'd2, 16'h0000, 0, 0, 16'd0, 0},
        '{0, rcs_pkg::CFG_IDX_DOC_COUNT, 7'd0, 16'h0001, 1, 0, 16'd0, 0},
        '{0, rcs_pkg::CFG_IDX_DOC_COUNT, 7'd0, 16'h0000, 2, 0, 16'd0, 0},
        '{0, rcs_pkg::CFG_IDX_DOC_COUNT, 7'd0, 16'h0001, 1, 0, 16'd0, 0},
        '{0, rcs_pkg::CFG_IDX_DOC_COUNT, 7'd0, 16'hFFFF, 2, 0, 16'd0, 0},
        '{0, rcs_pkg::CFG_IDX_DOC_COUNT, 7'd0, 16'h0000, 2, 0, 16'd0, 0},
        // doc count above range saturates to sixteen rows
        '{1, rcs_pkg::CFG_IDX_DOC_COUNT, 7'd31, 16'h0000, 0, 0, 16'd0, 0},
        '{1, rcs_pkg::CFG_IDX_TERMS,     7'd1,  16'h0000, 0, 0, 16'd0, 0},
        '{0, rcs_pkg::CFG_IDX_DOC_COUNT, 7'd0,  16'hAAAA, 16, 0, 16'd0, 0},
        // term count above range saturates to the widest row
        '{1, rcs_pkg::CFG_IDX_DOC_COUNT, 7'd1,   16'h0000, 0, 0, 16'd0, 0},
        '{1, rcs_pkg::CFG_IDX_TERMS,     7'd127, 16'h0000, 0, 0, 16'd0, 0},
        '{0, rcs_pkg::CFG_IDX_DOC_COUNT, 7'd0,   16'h5555, 63, 0, 16'd0, 0},
        '{0, rcs_pkg::CFG_IDX_DOC_COUNT, 7'd0,   16'h5555, 1, 1, 16'd32768, 0},
        // shrink the matrix mid-load: the next count starts the run at once
        '{1, rcs_pkg::CFG_IDX_DOC_COUNT, 7'd4, 16'h0000, 0, 0, 16'd0, 0},
        '{1, rcs_pkg::CFG_IDX_TERMS,     7'd4, 16'h0000, 0, 0, 16'd0, 0},
        '{0, rcs_pkg::CFG_IDX_DOC_COUNT, 7'd0, 16'h00FF, 10, 0, 16'd0, 0},
        '{1, rcs_pkg::CFG_IDX_DOC_COUNT, 7'd2, 16'h0000, 0, 0, 16'd0, 0}
    };

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [rcs_pkg::IN_DATA_W-1:0] row_buf [rcs_pkg::DEF_MAX_TERMS];
        logic [rcs_pkg::IN_DATA_W-1:0] v;
        int unsigned docs;
        int unsigned terms;
        int          sel;
        int          mode;
        int          rand_items;

        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = rcs_pkg::CFG_IDX_DOC_COUNT;
        i_cfg_data  = '0;
        i_m_tready  = 1'b0;
        error_count  = 0;
        results_seen = 0;
        cycle_count  = 0;
        quiet        = 1'b0;
        hold_done    = 1'b0;
        fill_pos     = 0;
        docs_reg     = rcs_pkg::DOC_COUNT_W'(1);
        terms_reg    = rcs_pkg::TERMS_W'(1);
        foreach (count_mem[k]) count_mem[k] = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].is_cfg) begin
                write_reg(plan[r].idx, plan[r].data);
            end else begin
                for (int n = 0; n < plan[r].rep; n++) send_count(plan[r].value);
                if (plan[r].chk) begin
                    pending_q[pending_q.size() - 1].sim  = plan[r].sim;
                    pending_q[pending_q.size() - 1].zero = plan[r].zero;
                end
            end
        end
        send_count(16'hFF00);   // completes the shrunken matrix

        // random matrices, mostly small, with empty and repeated rows
        rand_items = 0;
        while (rand_items < 140 || results_seen + pending_q.size() < 48) begin
            sel = $urandom_range(11);
            case (sel)
                0: begin docs = 16; terms = $urandom_range(1, 3); end
                1: begin docs = $urandom_range(17, 31); terms = $urandom_range(1, 2); end
                2: begin docs = $urandom_range(1, 2); terms = $urandom_range(33, 64); end
                3: begin docs = 0; terms = $urandom_range(1, 6); end
                default: begin
                    docs  = $urandom_range(1, 6);
                    terms = $urandom_range(1, 8);
                end
            endcase
            write_reg(rcs_pkg::CFG_IDX_DOC_COUNT, rcs_pkg::CFG_DATA_W'(docs));
            write_reg(rcs_pkg::CFG_IDX_TERMS, rcs_pkg::CFG_DATA_W'(terms));
            docs = clip_reg(docs, rcs_pkg::DEF_MAX_DOCS);
            for (int unsigned d = 0; d < docs; d++) begin
                mode = $urandom_range(5);
                for (int unsigned t = 0; t < terms; t++) begin
                    case (mode)
                        0: v = '0;
                        1: v = (d == 0) ? rcs_pkg::IN_DATA_W'($urandom) : row_buf[t];
                        2: v = $urandom_range(0, 3);
                        default: v = $urandom;
                    endcase
                    row_buf[t] = v;
                    send_count(v);
                    rand_items++;
                    if (rand_items >= 110) quiet = 1'b1;
                end
            end
        end
        i_s_tvalid <= 1'b0;

        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/rcs_pkg.sv
src/rcs_ram.sv
src/rcs_ctrl.sv
src/rcs_dpath.sv
src/ring_cosine_similarity_unit.sv
bench/tb_ring_cosine_similarity_unit.sv
